FILE: hw/rtl/msr_pkg.sv
// msr_pkg: codes and constants for the motor speed ramp
// no dependencies; imported by the interfaces, the top level and its checker

package msr_pkg;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MOVE_FWD   = 2'd0,
    MOVE_SPIN  = 2'd1,
    MOVE_NONE2 = 2'd2,
    MOVE_NONE3 = 2'd3
  } move_e;

  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_LEFT     = 2'd1,
    TURN_RIGHT    = 2'd2,
    TURN_NONE     = 2'd3
  } turn_e;

  typedef enum logic [2:0] {
    DRV_NONE       = 3'd0,
    DRV_FWD        = 3'd1,
    DRV_FWD_LEFT   = 3'd2,
    DRV_FWD_RIGHT  = 3'd3,
    DRV_STOP       = 3'd4,
    DRV_SPIN_LEFT  = 3'd5,
    DRV_SPIN_RIGHT = 3'd6
  } drive_e;

  localparam logic [7:0] MinSpeedReset = 8'd50;
  localparam logic [7:0] RampCap       = 8'd220;
  localparam logic [7:0] StepFineThr   = 8'd180;
  localparam logic [7:0] StepMidThr    = 8'd140;
  localparam logic [7:0] StepFine      = 8'd1;
  localparam logic [7:0] StepMid       = 8'd2;
  localparam logic [7:0] StepCoarse    = 8'd8;

  localparam logic [7:0] InnerThr0 = 8'd80;
  localparam logic [7:0] InnerThr1 = 8'd120;
  localparam logic [7:0] InnerThr2 = 8'd160;
  localparam logic [7:0] InnerThr3 = 8'd220;
  localparam logic [7:0] InnerCut0 = 8'd30;
  localparam logic [7:0] InnerCut1 = 8'd60;
  localparam logic [7:0] InnerCut2 = 8'd100;
  localparam logic [7:0] InnerCut3 = 8'd150;
  localparam logic [7:0] InnerCut4 = 8'd30;

endpackage

FILE: hw/rtl/msr_if.sv
// msr_cmd_if and msr_drv_if: valid/ready channels for command and drive beats
// depends on msr_pkg

interface msr_cmd_if
  import msr_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] move_req;
  logic [1:0] turn_req;
  logic [7:0] speed_req;

  modport source (output valid, op, move_req, turn_req, speed_req, input ready);
  modport sink   (input valid, op, move_req, turn_req, speed_req, output ready);
endinterface

interface msr_drv_if
  import msr_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [2:0] drive_cmd;
  logic [7:0] outer_speed;
  logic [7:0] inner_speed;

  modport source (output valid, drive_cmd, outer_speed, inner_speed, input ready);
  modport sink   (input valid, drive_cmd, outer_speed, inner_speed, output ready);
endinterface

FILE: hw/rtl/motor_speed_ramp_with_direction_latch.sv
// motor_speed_ramp_with_direction_latch: speed ramp with direction latch, top level
// depends on msr_pkg and the msr_cmd_if / msr_drv_if channels
//
// channel    dir  beat                                       result
// cmd_i      in   op, move_req, turn_req, speed_req          tick gives one drive beat
// drv_o      out  drive_cmd, outer_speed, inner_speed        -
// min_speed  in   write enable and 8 bit value               -
//
// one beat per cycle while not held off; a tick's drive beat is in the output register the cycle after acceptance
// the rate is set by the single output register, which reloads as it is emptied
// cmd_i is held off only while a drive beat waits and drv_o.ready is low
// reset clears all state but the output data registers, min_speed returns to 50, no clearing pass

module motor_speed_ramp_with_direction_latch
  import msr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       min_speed_we_i,
  input  logic [7:0] min_speed_i,
  msr_cmd_if.sink    cmd_i,
  msr_drv_if.source  drv_o
);

  logic [7:0] min_speed_q;
  logic [1:0] pend_move_q, pend_turn_q, lat_move_q, lat_turn_q;
  logic [7:0] ramp_q, target_q;
  logic       out_valid_q;
  logic [2:0] out_cmd_q;
  logic [7:0] out_outer_q, out_inner_q;

  logic       accept, tick, latch_en;
  logic [1:0] lat_move_d, lat_turn_d;
  logic [7:0] step, ramp_d, target_d, inner_cut;
  logic       ramp_up, ramp_down;
  drive_e     cmd_d;
  logic [7:0] outer_d, inner_d;

  assign cmd_i.ready = !out_valid_q || drv_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign tick        = (op_e'(cmd_i.op) == OP_TICK);

  assign latch_en   = (ramp_q <= min_speed_q);
  assign lat_move_d = latch_en ? pend_move_q : lat_move_q;
  assign lat_turn_d = latch_en ? pend_turn_q : lat_turn_q;

  always_comb begin
    priority if (target_q > StepFineThr) begin
      step = StepFine;
    end else if (target_q > StepMidThr) begin
      step = StepMid;
    end else begin
      step = StepCoarse;
    end
  end

  assign ramp_up   = (ramp_q < target_q) && (ramp_q < RampCap);
  assign ramp_down = (ramp_q > target_q) && (ramp_q > min_speed_q);

  always_comb begin
    priority if (ramp_up) begin
      ramp_d = ramp_q + step;
    end else if (ramp_down) begin
      ramp_d = (ramp_q >= step) ? (ramp_q - step) : 8'd0;
    end else begin
      ramp_d = ramp_q;
    end
  end

  // inner wheel reduction by speed band
  always_comb begin
    priority if (ramp_d <= InnerThr0) begin
      inner_cut = InnerCut0;
    end else if (ramp_d <= InnerThr1) begin
      inner_cut = InnerCut1;
    end else if (ramp_d <= InnerThr2) begin
      inner_cut = InnerCut2;
    end else if (ramp_d <= InnerThr3) begin
      inner_cut = InnerCut3;
    end else begin
      inner_cut = InnerCut4;
    end
  end

  always_comb begin
    cmd_d   = DRV_NONE;
    outer_d = 8'd0;
    inner_d = 8'd0;
    unique case (move_e'(lat_move_d))
      MOVE_FWD: begin
        unique case (turn_e'(lat_turn_d))
          TURN_STRAIGHT: begin
            cmd_d   = DRV_FWD;
            outer_d = ramp_d;
          end
          TURN_LEFT, TURN_RIGHT: begin
            cmd_d   = (turn_e'(lat_turn_d) == TURN_LEFT) ? DRV_FWD_LEFT : DRV_FWD_RIGHT;
            outer_d = ramp_d;
            inner_d = (ramp_d >= inner_cut) ? (ramp_d - inner_cut) : 8'd0;
          end
          default: cmd_d = DRV_NONE;
        endcase
      end
      MOVE_SPIN: begin
        unique case (turn_e'(lat_turn_d))
          TURN_STRAIGHT: cmd_d = DRV_STOP;
          TURN_LEFT, TURN_RIGHT: begin
            cmd_d   = (turn_e'(lat_turn_d) == TURN_LEFT) ? DRV_SPIN_LEFT : DRV_SPIN_RIGHT;
            outer_d = ramp_d;
          end
          default: cmd_d = DRV_NONE;
        endcase
      end
      default: cmd_d = DRV_NONE;
    endcase
  end

  assign target_d = (cmd_i.move_req != lat_move_q) ? min_speed_q : cmd_i.speed_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= MinSpeedReset;
    end else if (min_speed_we_i) begin
      min_speed_q <= min_speed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_move_q <= 2'd0;
      pend_turn_q <= 2'd0;
      lat_move_q  <= 2'd0;
      lat_turn_q  <= 2'd0;
      ramp_q      <= 8'd0;
      target_q    <= 8'd0;
    end else if (accept) begin
      if (tick) begin
        lat_move_q <= lat_move_d;
        lat_turn_q <= lat_turn_d;
        ramp_q     <= ramp_d;
      end else begin
        pend_move_q <= cmd_i.move_req;
        pend_turn_q <= cmd_i.turn_req;
        target_q    <= target_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && tick) begin
      out_valid_q <= 1'b1;
    end else if (drv_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && tick) begin
      out_cmd_q   <= cmd_d;
      out_outer_q <= outer_d;
      out_inner_q <= inner_d;
    end
  end

  assign drv_o.valid       = out_valid_q;
  assign drv_o.drive_cmd   = out_cmd_q;
  assign drv_o.outer_speed = out_outer_q;
  assign drv_o.inner_speed = out_inner_q;

endmodule

FILE: hw/rtl/msr_checker.sv
// msr_checker: port-level checks on the speed ramp, bound to the top level
// depends on msr_pkg and motor_speed_ramp_with_direction_latch

module msr_checker
  import msr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic       cmd_op_i,
  input logic       drv_valid_i,
  input logic       drv_ready_i,
  input logic [2:0] drv_cmd_i,
  input logic [7:0] drv_outer_i,
  input logic [7:0] drv_inner_i
);

  // a tick beat always lands in the output register
  a_tick_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i && (cmd_op_i == OP_TICK)) |=> drv_valid_i)
    else $error("tick beat produced no drive beat");

  // a waiting drive beat holds
  a_drv_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drv_valid_i && !drv_ready_i) |=> (drv_valid_i && $stable(drv_cmd_i)
      && $stable(drv_outer_i) && $stable(drv_inner_i)))
    else $error("drive beat changed while stalled");

  // no drive and stop carry no speed
  a_idle_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drv_valid_i && (drv_cmd_i == DRV_NONE || drv_cmd_i == DRV_STOP))
      |-> (drv_outer_i == 8'd0 && drv_inner_i == 8'd0))
    else $error("speed on idle drive command");

  // inner speed only on forward turns and never above outer
  a_inner_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drv_valid_i && drv_inner_i != 8'd0)
      |-> ((drv_cmd_i == DRV_FWD_LEFT || drv_cmd_i == DRV_FWD_RIGHT)
           && drv_inner_i < drv_outer_i))
    else $error("inner speed out of place");

endmodule

bind motor_speed_ramp_with_direction_latch msr_checker u_msr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .cmd_op_i    (cmd_i.op),
  .drv_valid_i (drv_o.valid),
  .drv_ready_i (drv_o.ready),
  .drv_cmd_i   (drv_o.drive_cmd),
  .drv_outer_i (drv_o.outer_speed),
  .drv_inner_i (drv_o.inner_speed)
);
